// File: rtl/jet_pkg.sv
// Package for the Julia escape-time block: widths, reset values and
// register indexes shared by the front, queue and iteration core.
package jet_pkg;
   localparam int CoordWidth = 32;
   localparam int StepWidth = 31;
   localparam int CountWidth = 25;
   localparam int PixWidth = 10;
   localparam int MaxImageSize = 1024;
   localparam int FractionBits = 28;

   localparam logic [2:0] REG_C_REAL = 3'd0;
   localparam logic [2:0] REG_C_IMAG = 3'd1;
   localparam logic [2:0] REG_VIEW_RE = 3'd2;
   localparam logic [2:0] REG_VIEW_IM = 3'd3;
   localparam logic [2:0] REG_PIXEL_STEP = 3'd4;
   localparam logic [2:0] REG_ITER_LIMIT = 3'd5;

   localparam logic signed [31:0] C_REAL_RESET = -32'sd104689828;
   localparam logic signed [31:0] C_IMAG_RESET = 32'sd161061274;
   localparam logic [30:0] PIXEL_STEP_RESET = 31'd524288;
   localparam logic [24:0] ITER_LIMIT_RESET = 25'd256;

   // start point handed from front to core
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic frame_start;
   } point_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7fff_ffff) r = 32'sh7fff_ffff;
      else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// File: rtl/julia_escape_time.sv
// Julia escape-time block: pixel in, escape count and frame statistics out.
// The iteration core takes a new pixel only when idle, after its multiply/update
// loop has finished the last one; the front end works ahead through a 2-entry queue.
// Reset (synchronous, active high) restores register defaults and clears frame state.
module julia_escape_time import jet_pkg::*; #(
   parameter int MAX_IMAGE_SIZE = MaxImageSize,
   parameter int FRACTION_BITS = FractionBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pixel_x[9:0], pixel_y[19:10], frame_start[20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // escape_count[24:0], escaped[25],
                                   // max_count_so_far[50:26], bounded_seen[51]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic signed [31:0] c_real_ff, c_imag_ff, x_off_ff, y_off_ff;
   logic [StepWidth-1:0] step_ff;
   logic [CountWidth-1:0] limit_ff;
   logic f_valid, f_ready, c_valid, c_ready;
   point_type f_point, c_point;
   logic [CountWidth-1:0] cnt, mx;
   logic esc, bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff <= C_REAL_RESET;
         c_imag_ff <= C_IMAG_RESET;
         x_off_ff <= '0;
         y_off_ff <= '0;
         step_ff <= PIXEL_STEP_RESET;
         limit_ff <= ITER_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_C_REAL:     c_real_ff <= csr_wdata;
            REG_C_IMAG:     c_imag_ff <= csr_wdata;
            REG_VIEW_RE:    x_off_ff <= csr_wdata;
            REG_VIEW_IM:    y_off_ff <= csr_wdata;
            REG_PIXEL_STEP: step_ff <= csr_wdata[StepWidth-1:0];
            REG_ITER_LIMIT: limit_ff <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   jet_front #(.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE), .FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .pixel_x(req_tdata[9:0]), .pixel_y(req_tdata[19:10]), .frame_start(req_tdata[20]),
      .view_re(x_off_ff), .view_im(y_off_ff), .pixel_step(step_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_point(f_point)
   );

   jet_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_point(f_point),
      .out_valid(c_valid), .out_ready(c_ready), .out_point(c_point)
   );

   jet_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
      .clock(clock), .reset(reset),
      .in_valid(c_valid), .in_ready(c_ready), .in_point(c_point),
      .c_real(c_real_ff), .c_imag(c_imag_ff), .iteration_limit(limit_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .escape_count(cnt), .escaped(esc), .max_count_so_far(mx), .bounded_seen(bnd)
   );

   assign rsp_tdata = {4'd0, bnd, mx, esc, cnt};
endmodule

// File: rtl/jet_front.sv
// Front end: maps a pixel index to a saturated start point.
// Depends on jet_pkg. Two register stages: multiply, then add and saturate.
module jet_front import jet_pkg::*; #(
   parameter int MAX_IMAGE_SIZE = MaxImageSize,
   parameter int FRACTION_BITS = FractionBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [PixWidth-1:0]     pixel_x,
   input  logic [PixWidth-1:0]     pixel_y,
   input  logic                    frame_start,
   input  logic signed [31:0]      view_re,
   input  logic signed [31:0]      view_im,
   input  logic [StepWidth-1:0]    pixel_step,
   output logic                    out_valid,
   input  logic                    out_ready,
   output point_type               out_point
);
   localparam logic signed [65:0] Minus1 = -(66'sd1 <<< FRACTION_BITS);

   logic                  s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic [StepWidth+PixWidth-1:0] px_prod_ff, py_prod_ff;
   logic                  fs1_ff;
   point_type             pt_ff;
   logic [PixWidth-1:0]   xi, yi;
   logic                  adv1, adv2;

   // index modulo image size by shifted compare and subtract
   function automatic logic [PixWidth-1:0] wrap_index(input logic [PixWidth-1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int k = PixWidth - 1; k >= 0; k--) begin
         if (r >= (32'(MAX_IMAGE_SIZE) << k)) r = r - (32'(MAX_IMAGE_SIZE) << k);
      end
      return r[PixWidth-1:0];
   endfunction

   assign xi = wrap_index(pixel_x);
   assign yi = wrap_index(pixel_y);

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign in_ready = adv1;
   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign out_valid = s2_valid_ff;
   assign out_point = pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (adv1) begin
         px_prod_ff <= pixel_step * (StepWidth+PixWidth)'(xi);
         py_prod_ff <= pixel_step * (StepWidth+PixWidth)'(yi);
         fs1_ff <= frame_start;
      end
      if (adv2) begin
         pt_ff.x <= sat32(Minus1 + 66'(view_re) + $signed({25'd0, px_prod_ff}));
         pt_ff.y <= sat32(Minus1 + 66'(view_im) + $signed({25'd0, py_prod_ff}));
         pt_ff.frame_start <= fs1_ff;
      end
   end
endmodule

// File: rtl/jet_queue.sv
// Short queue between front end and iteration core.
// Depends on jet_pkg for the point type.
module jet_queue import jet_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  point_type in_point,
   output logic      out_valid,
   input  logic      out_ready,
   output point_type out_point
);
   point_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push, pop;

   assign in_ready = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_point = mem_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
      if (push) mem_ff[wr_ptr_ff] <= in_point;
   end
endmodule

// File: rtl/jet_core.sv
// Iteration core: runs z = z*z + c per point and keeps frame statistics.
// Depends on jet_pkg. Per iteration: a squaring step, then an update step.
module jet_core import jet_pkg::*; #(
   parameter int FRACTION_BITS = FractionBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  point_type             in_point,
   input  logic signed [31:0]    c_real,
   input  logic signed [31:0]    c_imag,
   input  logic [CountWidth-1:0] iteration_limit,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CountWidth-1:0] escape_count,
   output logic                  escaped,
   output logic [CountWidth-1:0] max_count_so_far,
   output logic                  bounded_seen
);
   localparam bit CanEscape = (2 * FRACTION_BITS + 2) < 64;
   localparam logic [64:0] Threshold = CanEscape ? (65'd1 << (2 * FRACTION_BITS + 2)) : 65'd0;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_MUL = 4'b0010, ST_STEP = 4'b0100, ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] x_ff, y_ff;
   logic signed [63:0] xx_ff, yy_ff, xy_ff;
   logic [CountWidth-1:0] cnt_ff, max_ff;
   logic bnd_ff, esc_ff, fs_ff;
   logic rsp_valid_ff;
   logic [CountWidth-1:0] rsp_cnt_ff, rsp_max_ff;
   logic rsp_esc_ff, rsp_bnd_ff;
   logic [64:0] mag;
   logic signed [64:0] diff;
   logic signed [65:0] nr, ni;
   logic [CountWidth-1:0] base_max;
   logic base_bnd;
   logic rsp_fire;

   assign mag = 65'($unsigned(xx_ff)) + 65'($unsigned(yy_ff));
   assign diff = 65'(xx_ff) - 65'(yy_ff);
   assign nr = 66'(diff >>> FRACTION_BITS) + 66'(c_real);
   assign ni = 66'(xy_ff >>> (FRACTION_BITS - 1)) + 66'(c_imag);
   assign base_max = fs_ff ? CountWidth'(1) : max_ff;
   assign base_bnd = fs_ff ? 1'b0 : bnd_ff;
   assign rsp_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || out_ready);

   assign in_ready = state_ff == ST_IDLE;
   assign out_valid = rsp_valid_ff;
   assign escape_count = rsp_cnt_ff;
   assign escaped = rsp_esc_ff;
   assign max_count_so_far = rsp_max_ff;
   assign bounded_seen = rsp_bnd_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_MUL;
         ST_MUL:  state_in = (cnt_ff >= iteration_limit) ? ST_DONE : ST_STEP;
         ST_STEP: state_in = (CanEscape && mag > Threshold) ? ST_DONE : ST_MUL;
         ST_DONE: if (!rsp_valid_ff || out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff <= CountWidth'(1);
         bnd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_fire || (rsp_valid_ff && !out_ready);
         if (rsp_fire) begin
            if (esc_ff) begin
               max_ff <= (cnt_ff > base_max) ? cnt_ff : base_max;
               bnd_ff <= base_bnd;
            end else begin
               max_ff <= base_max;
               bnd_ff <= 1'b1;
            end
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            x_ff <= in_point.x;
            y_ff <= in_point.y;
            fs_ff <= in_point.frame_start;
            cnt_ff <= '0;
            esc_ff <= 1'b0;
         end
         ST_MUL: begin
            xx_ff <= x_ff * x_ff;
            yy_ff <= y_ff * y_ff;
            xy_ff <= x_ff * y_ff;
         end
         ST_STEP: begin
            if (CanEscape && mag > Threshold) esc_ff <= 1'b1;
            else begin
               x_ff <= sat32(nr);
               y_ff <= sat32(ni);
               cnt_ff <= cnt_ff + CountWidth'(1);
            end
         end
         ST_DONE: begin
            if (rsp_fire) begin
               rsp_cnt_ff <= cnt_ff;
               rsp_esc_ff <= esc_ff;
               rsp_max_ff <= esc_ff ? ((cnt_ff > base_max) ? cnt_ff : base_max) : base_max;
               rsp_bnd_ff <= esc_ff ? base_bnd : 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule
